/* rtl/ppg_pulse_rate_detector_defines.svh */
// Assertion macros for the pulse rate detector.
`ifndef PPG_PULSE_RATE_DETECTOR_DEFINES_SVH
`define PPG_PULSE_RATE_DETECTOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/ppr_pkg.sv */
// Types, constants and helpers for the pulse rate detector.
package ppr_pkg;

  localparam int unsigned DIV_W = 41;
  localparam int unsigned PROD_W = 49;

  localparam logic [2:0] CFG_ALPHA     = 3'd0;
  localparam logic [2:0] CFG_MIN_THR   = 3'd1;
  localparam logic [2:0] CFG_MAX_THR   = 3'd2;
  localparam logic [2:0] CFG_RATE_MIN  = 3'd3;
  localparam logic [2:0] CFG_RATE_MAX  = 3'd4;
  localparam logic [2:0] CFG_GAP_RESET = 3'd5;

  localparam logic signed [16:0] LP_B = 17'sd16072;
  localparam logic signed [16:0] LP_A = 17'sd33392;
  localparam logic [DIV_W-1:0] RATE_NUM = 41'd15360000;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_IR_MUL  = 19'h00002,
    S_IR_W    = 19'h00004,
    S_RED_MUL = 19'h00008,
    S_RED_W   = 19'h00010,
    S_MEAN    = 19'h00020,
    S_MDIV    = 19'h00040,
    S_MFIN    = 19'h00080,
    S_LPB     = 19'h00100,
    S_LPA     = 19'h00200,
    S_LPS     = 19'h00400,
    S_DET     = 19'h00800,
    S_RDIV    = 19'h01000,
    S_RCHK    = 19'h02000,
    S_RUPD    = 19'h04000,
    S_ADIV    = 19'h08000,
    S_AFIN    = 19'h10000,
    S_OUT     = 19'h20000
  } seq_state_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_UP   = 3'b010,
    PH_DOWN = 3'b100
  } phase_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ppr_if.sv */
// Valid/ready channels for sample beats and result beats.
interface ppr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_ir;
  logic [15:0] raw_red;
  logic [31:0] time_ms;
  modport source (output valid, raw_ir, raw_red, time_ms, input ready);
  modport sink (input valid, raw_ir, raw_red, time_ms, output ready);
endinterface

interface ppr_out_if;
  logic               valid;
  logic               ready;
  logic               pulse_detected;
  logic [15:0]        heart_rate;
  logic signed [31:0] ir_cardiogram;
  logic signed [31:0] ir_dc_level;
  logic signed [31:0] red_dc_level;
  logic [22:0]        beat_threshold;
  logic signed [31:0] ir_ac;
  logic signed [31:0] red_ac;
  modport source (output valid, pulse_detected, heart_rate, ir_cardiogram, ir_dc_level,
                  red_dc_level, beat_threshold, ir_ac, red_ac, input ready);
  modport sink (input valid, pulse_detected, heart_rate, ir_cardiogram, ir_dc_level,
                red_dc_level, beat_threshold, ir_ac, red_ac, output ready);
endinterface

/* rtl/ppr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/ppg_pulse_rate_detector.sv */
// A sample beat runs through DC removal, mean filter and low-pass to the detector; a detected
// peak adds a rate division, and a rate in range adds the average division before the result beat.
// A new sample is taken only after the previous result beat has been accepted, so a result
// beat that waits on ready also holds off the next sample.
// Cost is set by one 32x17 multiplier, shared by DC removal and low-pass, and one radix-2
// divider, shared by the mean filter, rate and average steps.
// Reset (async, active low): all filter and detector state clears, registers take defaults.
module ppg_pulse_rate_detector #(
  parameter int unsigned MEAN_DEPTH = 16,
  parameter int unsigned RATE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppr_in_if.sink      in_s,
  ppr_out_if.source   out_s,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import ppr_pkg::*;
  `include "ppg_pulse_rate_detector_defines.svh"

  localparam int unsigned MAW = MEAN_DEPTH > 1 ? $clog2(MEAN_DEPTH) : 1;
  localparam int unsigned RAW = RATE_DEPTH > 1 ? $clog2(RATE_DEPTH) : 1;
  localparam int unsigned MFW = $clog2(MEAN_DEPTH + 1);
  localparam int unsigned RFW = $clog2(RATE_DEPTH + 1);
  localparam int unsigned RSW = 16 + RFW;

  // configuration
  logic [15:0]        alpha_q;
  logic signed [31:0] min_thr_q, max_thr_q;
  logic [7:0]         rate_min_q, rate_max_q;
  logic [15:0]        gap_q;

  // sequencer and datapath state
  seq_state_e         state_q, state_d;
  phase_e             phase_q;
  logic [15:0]        raw_ir_q, raw_red_q;
  logic [31:0]        time_q;
  logic signed [31:0] ir_acc_q, red_acc_q, ir_ac_q, red_ac_q;
  logic signed [39:0] mean_sum_q;
  logic [MAW-1:0]     mean_pos_q;
  logic [MFW-1:0]     mean_fill_q;
  logic               mean_neg_q;
  logic signed [31:0] md_q, lp_older_q, lp_newer_q, card_q, prev_q;
  logic [31:0]        peak_time_q, last_peak_q;
  logic [22:0]        peak_level_q;
  logic [RSW-1:0]     rate_sum_q;
  logic [RAW-1:0]     rate_pos_q;
  logic [RFW-1:0]     rate_fill_q;
  logic [15:0]        avg_q;
  logic               pulse_q;
  logic signed [PROD_W-1:0] prod_q, acc_q;

  // shared divider
  logic [DIV_W-1:0]   quo_q;
  logic [32:0]        rem_q;
  logic [31:0]        dvs_q;
  logic [5:0]         cnt_q;
  logic               div_run, div_last;
  logic [33:0]        div_shift;
  logic [33:0]        div_diff;

  // RAM ports
  logic [31:0]        mean_rd;
  logic [15:0]        rate_rd;
  logic               mean_we, rate_we;

  // combinational temporaries
  logic signed [31:0]     mul_a;
  logic signed [16:0]     mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [63:0]     dc_x, dc_rnd, lp_rnd;
  logic signed [31:0]     dc_prev, dc_w, dc_ac;
  logic signed [39:0]     mean_old, mean_new;
  logic [MFW-1:0]         mean_fill_n;
  logic signed [40:0]     mean_q;
  logic signed [31:0]     md_n, lp_new, card_n;
  logic [31:0]            interval;
  logic [15:0]            rate_old;
  logic [RSW-1:0]         rate_sum_n;
  logic [RFW-1:0]         rate_fill_n;
  logic                   rate_bad;

  assign in_s.ready  = (state_q == S_IDLE);
  assign out_s.valid = (state_q == S_OUT);
  assign out_s.pulse_detected = pulse_q;
  assign out_s.heart_rate     = avg_q;
  assign out_s.ir_cardiogram  = card_q;
  assign out_s.ir_dc_level    = ir_acc_q;
  assign out_s.red_dc_level   = red_acc_q;
  assign out_s.beat_threshold = peak_level_q;
  assign out_s.ir_ac          = ir_ac_q;
  assign out_s.red_ac         = red_ac_q;

  assign div_run   = (state_q == S_MDIV) || (state_q == S_RDIV) || (state_q == S_ADIV);
  assign div_last  = (cnt_q == 6'(DIV_W - 1));
  assign div_shift = {rem_q, quo_q[DIV_W-1]};
  assign div_diff  = div_shift - {2'b00, dvs_q};

  assign mean_we = (state_q == S_MEAN);
  assign rate_we = (state_q == S_RUPD);

  ppr_ram #(.WIDTH(32), .DEPTH(MEAN_DEPTH)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i (mean_pos_q),
    .wdata_i (ir_ac_q),
    .raddr_i (mean_pos_q),
    .rdata_o (mean_rd)
  );

  ppr_ram #(.WIDTH(16), .DEPTH(RATE_DEPTH)) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (rate_we),
    .waddr_i (rate_pos_q),
    .wdata_i (quo_q[15:0]),
    .raddr_i (rate_pos_q),
    .rdata_o (rate_rd)
  );

  always_comb begin
    unique case (state_q)
      S_IR_MUL:  begin mul_a = ir_acc_q;   mul_b = signed'({1'b0, alpha_q}); end
      S_RED_MUL: begin mul_a = red_acc_q;  mul_b = signed'({1'b0, alpha_q}); end
      S_LPB:     begin mul_a = md_q;       mul_b = LP_B; end
      default:   begin mul_a = lp_newer_q; mul_b = LP_A; end
    endcase
    mul_p = PROD_W'(mul_a * mul_b);

    dc_prev = (state_q == S_IR_W) ? ir_acc_q : red_acc_q;
    dc_x    = (state_q == S_IR_W) ? {40'd0, raw_ir_q, 8'd0} : {40'd0, raw_red_q, 8'd0};
    dc_rnd  = (64'(prod_q) + 64'sd32768) >>> 16;
    dc_w    = sat32(dc_x + dc_rnd);
    dc_ac   = sat32(64'(dc_w) - 64'(dc_prev));

    mean_old    = (mean_fill_q == MFW'(MEAN_DEPTH)) ? 40'(signed'(mean_rd)) : 40'sd0;
    mean_new    = mean_sum_q - mean_old + 40'(ir_ac_q);
    mean_fill_n = (mean_fill_q == MFW'(MEAN_DEPTH)) ? mean_fill_q : mean_fill_q + 1'b1;
    mean_q      = mean_neg_q ? -signed'(quo_q) : signed'(quo_q);
    md_n        = sat32(64'(mean_q) - 64'(ir_ac_q));

    lp_rnd = (64'(acc_q) + 64'(prod_q) + 64'sd32768) >>> 16;
    lp_new = sat32(lp_rnd);
    card_n = sat32(64'(lp_newer_q) + 64'(lp_new));

    interval = peak_time_q - last_peak_q;

    rate_bad = (quo_q > DIV_W'({rate_max_q, 8'd0})) || (quo_q < DIV_W'({rate_min_q, 8'd0}));
    rate_old    = (rate_fill_q == RFW'(RATE_DEPTH)) ? rate_rd : 16'd0;
    rate_sum_n  = rate_sum_q - RSW'(rate_old) + RSW'(quo_q[15:0]);
    rate_fill_n = (rate_fill_q == RFW'(RATE_DEPTH)) ? rate_fill_q : rate_fill_q + 1'b1;

    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_s.valid) begin state_d = S_IR_MUL; end
      S_IR_MUL:  state_d = S_IR_W;
      S_IR_W:    state_d = S_RED_MUL;
      S_RED_MUL: state_d = S_RED_W;
      S_RED_W:   state_d = S_MEAN;
      S_MEAN:    state_d = S_MDIV;
      S_MDIV:    if (div_last) begin state_d = S_MFIN; end
      S_MFIN:    state_d = S_LPB;
      S_LPB:     state_d = S_LPA;
      S_LPA:     state_d = S_LPS;
      S_LPS:     state_d = S_DET;
      S_DET: begin
        if (card_q <= max_thr_q && phase_q == PH_UP && !(card_q > prev_q) &&
            interval != 32'd0) begin
          state_d = S_RDIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RDIV:    if (div_last) begin state_d = S_RCHK; end
      S_RCHK:    state_d = rate_bad ? S_OUT : S_RUPD;
      S_RUPD:    state_d = S_ADIV;
      S_ADIV:    if (div_last) begin state_d = S_AFIN; end
      S_AFIN:    state_d = S_OUT;
      S_OUT:     if (out_s.ready) begin state_d = S_IDLE; end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= 16'd62259;
      min_thr_q  <= 32'sd25600;
      max_thr_q  <= 32'sd512000;
      rate_min_q <= 8'd50;
      rate_max_q <= 8'd220;
      gap_q      <= 16'd2500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA:     alpha_q    <= cfg_wdata_i[15:0];
        CFG_MIN_THR:   min_thr_q  <= cfg_wdata_i;
        CFG_MAX_THR:   max_thr_q  <= cfg_wdata_i;
        CFG_RATE_MIN:  rate_min_q <= cfg_wdata_i[7:0];
        CFG_RATE_MAX:  rate_max_q <= cfg_wdata_i[7:0];
        CFG_GAP_RESET: gap_q      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // divider: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (div_run) begin
      if (!div_diff[33]) begin
        rem_q <= div_diff[32:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= div_shift[32:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
    end else begin
      cnt_q <= 6'd0;
      rem_q <= 33'd0;
      unique case (state_q)
        S_MEAN: begin
          quo_q <= DIV_W'(mean_new < 0 ? -mean_new : mean_new);
          dvs_q <= 32'(mean_fill_n);
        end
        S_DET: begin
          quo_q <= RATE_NUM + DIV_W'(interval[31:1]);
          dvs_q <= interval;
        end
        S_RUPD: begin
          quo_q <= DIV_W'(rate_sum_n);
          dvs_q <= 32'(rate_fill_n);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      raw_ir_q  <= in_s.raw_ir;
      raw_red_q <= in_s.raw_red;
      time_q    <= in_s.time_ms;
    end
    if (state_q == S_IR_MUL || state_q == S_RED_MUL || state_q == S_LPB ||
        state_q == S_LPA) begin
      prod_q <= mul_p;
    end
    if (state_q == S_LPA) begin
      acc_q <= prod_q;
    end
    if (state_q == S_MEAN) begin
      mean_neg_q <= (mean_new < 0);
    end
    if (state_q == S_MFIN) begin
      md_q <= md_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_IDLE;
      ir_acc_q     <= '0;
      red_acc_q    <= '0;
      ir_ac_q      <= '0;
      red_ac_q     <= '0;
      mean_sum_q   <= '0;
      mean_pos_q   <= '0;
      mean_fill_q  <= '0;
      lp_older_q   <= '0;
      lp_newer_q   <= '0;
      card_q       <= '0;
      prev_q       <= '0;
      peak_time_q  <= '0;
      last_peak_q  <= '0;
      peak_level_q <= '0;
      rate_sum_q   <= '0;
      rate_pos_q   <= '0;
      rate_fill_q  <= '0;
      avg_q        <= '0;
      pulse_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: pulse_q <= 1'b0;
        S_IR_W: begin
          ir_acc_q <= dc_w;
          ir_ac_q  <= dc_ac;
        end
        S_RED_W: begin
          red_acc_q <= dc_w;
          red_ac_q  <= dc_ac;
        end
        S_MEAN: begin
          mean_sum_q  <= mean_new;
          mean_fill_q <= mean_fill_n;
          mean_pos_q  <= (32'(mean_pos_q) + 32'd1 >= MEAN_DEPTH) ? '0 : mean_pos_q + 1'b1;
        end
        S_LPS: begin
          lp_older_q <= lp_newer_q;
          lp_newer_q <= lp_new;
          card_q     <= card_n;
        end
        S_DET: begin
          if (card_q > max_thr_q) begin
            phase_q      <= PH_IDLE;
            prev_q       <= '0;
            last_peak_q  <= '0;
            peak_time_q  <= '0;
            peak_level_q <= '0;
          end else begin
            unique case (phase_q)
              PH_UP: begin
                if (card_q > prev_q) begin
                  peak_time_q  <= time_q;
                  peak_level_q <= (card_q > 0) ? card_q[30:8] : 23'd0;
                  prev_q       <= card_q;
                end else begin
                  last_peak_q <= peak_time_q;
                  phase_q     <= PH_DOWN;
                  if (interval > 32'(gap_q)) begin
                    rate_sum_q  <= '0;
                    rate_pos_q  <= '0;
                    rate_fill_q <= '0;
                  end
                end
              end
              PH_DOWN: begin
                if (card_q < min_thr_q) begin
                  phase_q <= PH_IDLE;
                end
                prev_q <= card_q;
              end
              default: begin
                if (card_q >= min_thr_q) begin
                  phase_q <= PH_UP;
                end
                prev_q <= card_q;
              end
            endcase
          end
        end
        S_RUPD: begin
          rate_sum_q  <= rate_sum_n;
          rate_fill_q <= rate_fill_n;
          rate_pos_q  <= (32'(rate_pos_q) + 32'd1 >= RATE_DEPTH) ? '0 : rate_pos_q + 1'b1;
        end
        S_AFIN: begin
          avg_q   <= (quo_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];
          pulse_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `PPR_ASSERT(a_no_overlap, !(in_s.ready && out_s.valid), "input and output open together")
  `PPR_ASSERT(a_accept_start, (in_s.valid && in_s.ready) |=> (state_q == S_IR_MUL), "sample beat did not start")
  `PPR_ASSERT(a_pulse_has_rate, (out_s.valid && pulse_q) |-> (rate_fill_q != '0), "pulse with empty rate window")
  `PPR_ASSERT_ALWAYS(a_fill_bound, !rst_ni || ((rate_fill_q <= RFW'(RATE_DEPTH)) &&
                     (mean_fill_q <= MFW'(MEAN_DEPTH))), "fill count overrun")
endmodule

/* sim/ppg_pulse_rate_detector_tb.sv */
// Self-checking testbench: predicts every result beat of the pulse rate detector.
module ppg_pulse_rate_detector_tb;
  import ppr_pkg::*;

  localparam int MEAN_N = 16;
  localparam int RATE_N = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        pulse;
    logic [15:0] rate;
    logic [31:0] card;
    logic [31:0] ir_dc;
    logic [31:0] red_dc;
    logic [22:0] thr;
    logic [31:0] ir_ac;
    logic [31:0] red_ac;
  } beat_t;

  typedef enum logic [1:0] {DET_IDLE, DET_UP, DET_DOWN} det_e;

  class pulse_scoreboard;
    logic [15:0] alpha;
    logic signed [31:0] min_thr, max_thr;
    logic [7:0] rate_lo, rate_hi;
    logic [15:0] gap_ms;
    logic signed [31:0] ir_acc, red_acc;
    logic signed [31:0] mwin[MEAN_N];
    longint msum;
    int mpos, mfill;
    logic signed [31:0] lp_old, lp_new;
    det_e phase;
    logic signed [31:0] prev_v;
    logic [31:0] pk_time, last_pk;
    logic [22:0] pk_level;
    logic [15:0] rwin[RATE_N];
    longint rsum;
    int rpos, rfill;
    logic [15:0] avg_rate;
    beat_t pending[$];
    int errors, checked, pulses;

    function new();
      alpha = 16'd62259; min_thr = 25600; max_thr = 512000;
      rate_lo = 8'd50; rate_hi = 8'd220; gap_ms = 16'd2500;
      ir_acc = 0; red_acc = 0; msum = 0; mpos = 0; mfill = 0;
      lp_old = 0; lp_new = 0; phase = DET_IDLE; prev_v = 0;
      pk_time = 0; last_pk = 0; pk_level = 0; avg_rate = 0;
      foreach (mwin[i]) mwin[i] = 0;
      clear_rates();
      errors = 0; checked = 0; pulses = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_ALPHA:     alpha = d[15:0];
        CFG_MIN_THR:   min_thr = d;
        CFG_MAX_THR:   max_thr = d;
        CFG_RATE_MIN:  rate_lo = d[7:0];
        CFG_RATE_MAX:  rate_hi = d[7:0];
        CFG_GAP_RESET: gap_ms = d[15:0];
        default: ;
      endcase
    endfunction

    function void clear_rates();
      foreach (rwin[i]) rwin[i] = 0;
      rsum = 0; rpos = 0; rfill = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint rnd16(longint p);
      return (p + 32768) >>> 16;
    endfunction

    function logic signed [31:0] leak(logic [15:0] raw, ref logic signed [31:0] acc);
      longint prior, w;
      prior = acc;
      w = clamp32(longint'(raw) * 256 + rnd16(prior * longint'(alpha)));
      acc = w;
      return clamp32(w - prior);
    endfunction

    function bit run_detector(logic signed [31:0] v, logic [31:0] now);
      logic [31:0] d;
      longint r;
      if (v > max_thr) begin
        phase = DET_IDLE; prev_v = 0; last_pk = 0; pk_time = 0; pk_level = 0;
        return 0;
      end
      if (phase == DET_UP) begin
        if (v > prev_v) begin
          pk_time = now;
          pk_level = v > 0 ? v[30:8] : 23'd0;
        end else begin
          d = pk_time - last_pk;
          last_pk = pk_time;
          phase = DET_DOWN;
          if (d > gap_ms) clear_rates();
          if (d == 0) return 0;
          r = (longint'(15360000) + d / 2) / longint'(d);
          if (r > longint'(rate_hi) * 256 || r < longint'(rate_lo) * 256) return 0;
          rsum = rsum - rwin[rpos] + r;
          rwin[rpos] = r[15:0];
          if (rfill < RATE_N) rfill++;
          rpos = (rpos + 1) % RATE_N;
          r = rsum / rfill;
          avg_rate = r > 65535 ? 16'hFFFF : r[15:0];
          return 1;
        end
      end else if (phase == DET_DOWN) begin
        if (v < min_thr) phase = DET_IDLE;
      end else if (v >= min_thr) begin
        phase = DET_UP;
      end
      prev_v = v;
      return 0;
    endfunction

    function void note_sample(logic [15:0] ir, logic [15:0] red, logic [31:0] t);
      beat_t b;
      logic signed [31:0] iac, rac, md, card;
      longint tmp;
      iac = leak(ir, ir_acc);
      rac = leak(red, red_acc);
      msum = msum - mwin[mpos] + iac;
      mwin[mpos] = iac;
      mpos = (mpos + 1) % MEAN_N;
      if (mfill < MEAN_N) mfill++;
      md = clamp32(msum / mfill - iac);
      lp_old = lp_new;
      tmp = 16072 * longint'(md) + 33392 * longint'(lp_old);
      lp_new = clamp32(rnd16(tmp));
      card = clamp32(longint'(lp_old) + lp_new);
      b.pulse = run_detector(card, t);
      b.rate = avg_rate; b.card = card; b.ir_dc = ir_acc; b.red_dc = red_acc;
      b.thr = pk_level; b.ir_ac = iac; b.red_ac = rac;
      pending.push_back(b);
    endfunction

    function void check_result(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pulse) pulses++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch beat %0d: exp p=%b hr=%h card=%h idc=%h rdc=%h thr=%h iac=%h rac=%h,",
                   checked, want.pulse, want.rate, want.card, want.ir_dc, want.red_dc,
                   want.thr, want.ir_ac, want.red_ac,
                   " got p=%b hr=%h card=%h idc=%h rdc=%h thr=%h iac=%h rac=%h",
                   got.pulse, got.rate, got.card, got.ir_dc, got.red_dc, got.thr,
                   got.ir_ac, got.red_ac);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_ALPHA;
  logic [31:0] cfg_wdata_i = '0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int sent = 0;
  logic [31:0] clock_ms = 0;

  ppr_in_if  in_ch ();
  ppr_out_if out_ch ();
  pulse_scoreboard sb = new();

  ppg_pulse_rate_detector uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_ch.sink), .out_s(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.raw_ir = '0; in_ch.raw_red = '0; in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.pulse_detected, out_ch.heart_rate, out_ch.ir_cardiogram,
                         out_ch.ir_dc_level, out_ch.red_dc_level, out_ch.beat_threshold,
                         out_ch.ir_ac, out_ch.red_ac});
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("ppg_pulse_rate_detector_tb: done, errors");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] ir, logic [15:0] red, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.raw_ir <= ir; in_ch.raw_red <= red; in_ch.time_ms <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(ir, red, t);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
  endtask

  task automatic setup(logic [15:0] a, logic [31:0] lo, logic [31:0] hi,
                       logic [7:0] rmin, logic [7:0] rmax, logic [15:0] gap);
    drain();
    write_reg(CFG_ALPHA, a); write_reg(CFG_MIN_THR, lo); write_reg(CFG_MAX_THR, hi);
    write_reg(CFG_RATE_MIN, {24'd0, rmin}); write_reg(CFG_RATE_MAX, {24'd0, rmax});
    write_reg(CFG_GAP_RESET, {16'd0, gap});
    cfg_we_i <= 1'b0;
  endtask

  // Pulse-like waveform with random period, amplitude and sample spacing.
  task automatic send_pulses(int n);
    int period, amp, base, step_ms, ph;
    period = $urandom_range(40, 8);
    amp = $urandom_range(20000, 200);
    base = $urandom_range(30000, 5000);
    step_ms = $urandom_range(80, 2);
    ph = 0;
    for (int i = 0; i < n; i++) begin
      logic [15:0] ir;
      ir = 16'((ph < period / 3) ? base + amp * ph / (period / 3 + 1) : base);
      ir = ir + 16'($urandom_range(amp / 20));
      clock_ms = clock_ms + step_ms + $urandom_range(3);
      if ($urandom_range(99) < 2) clock_ms = clock_ms + $urandom_range(6000);
      send_sample(ir, 16'(base + $urandom_range(500)), clock_ms);
      ph = (ph + 1) % period;
    end
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_sample(16'($urandom), 16'($urandom),
                  ($urandom_range(3) == 0) ? $urandom : clock_ms + i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_sample(16'h0000, 16'h0000, 32'd0);
    send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 16'h0000, 32'd0);
    send_sample(16'h0000, 16'hFFFF, 32'd5);
    for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'hFFFF : 16'h0000, 16'h8000, 32'd10 * i);
    send_sample(16'h5555, 16'hAAAA, 32'h8000_0000);
    setup(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd255, 16'hFFFF);
    send_noise(4);
    send_pulses(150);
    setup(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd0, 16'h0000);
    send_noise(4);
    setup(16'd62259, 32'sd256, 32'h7FFF_FFFF, 8'd0, 8'd255, 16'd2500);
    send_sample(16'd20000, 16'd1, 32'd100);
    send_sample(16'd40000, 16'd1, 32'd100);
    for (int i = 0; i < 3; i++) send_sample(16'd0, 16'd1, 32'd100);
    drain();
    send_idle_pct = 29; recv_idle_pct = 53;
    for (int k = 0; k < 6; k++) begin
      send_pulses(90);
      send_noise(10);
    end
    setup(16'd62259, 32'sd25600, 32'sd512000, 8'd50, 8'd220, 16'd2500);
    send_idle_pct = 53; recv_idle_pct = 29;
    for (int k = 0; k < 6; k++) begin
      send_pulses(90);
      send_noise(10);
    end
    setup(16'($urandom_range(65535, 50000)), $urandom_range(20000), 32'h7FFF_FFFF,
          8'd30, 8'd250, 16'd3000);
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_pulses(20);
    join
    for (int k = 0; k < 4; k++) send_pulses(90);
    drain();
    $display("run covered %0d samples, %0d results checked, %0d accepted beats",
             sent, sb.checked, sb.pulses);
    $display("register settings: defaults, both extremes and random mid-range values");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ppg_pulse_rate_detector_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("ppg_pulse_rate_detector_tb: done, errors");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/ppr_pkg.sv
rtl/ppr_if.sv
rtl/ppr_ram.sv
rtl/ppg_pulse_rate_detector.sv
sim/ppg_pulse_rate_detector_tb.sv
